@@ sv/lfpd_pkg.sv @@
// shared types, constants and helper functions of the line follower pid drive
// no dependencies; imported by every module of the block
package lfpd_pkg;

  localparam int NUM_SENSORS_DEF = 5;

  // field and datapath widths
  localparam int GAIN_W     = 16;
  localparam int SPEED_W    = 11;
  localparam int ERR_W      = 11;
  localparam int INT_W      = 24;
  localparam int DIFF_W     = 12;
  localparam int PROD_W     = 41;
  localparam int ACC_W      = 43;
  localparam int SUM_W      = 44;
  localparam int FRAC_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int DIR_W      = 3;

  // error and integral limits
  localparam logic signed [ERR_W-1:0] ERR_MAX   = 11'sd1023;
  localparam logic signed [ERR_W-1:0] ERR_MIN   = -11'sd1024;
  localparam logic signed [ERR_W-1:0] HALF_UNIT = 11'sd128;
  localparam logic signed [INT_W-1:0] INT_MAX   = {1'b0, {(INT_W-1){1'b1}}};
  localparam logic signed [INT_W-1:0] INT_MIN   = {1'b1, {(INT_W-1){1'b0}}};

  // wheel drive constants
  localparam logic signed [SPEED_W-1:0] DRIVE_LIMIT  = 11'sd1000;
  localparam logic signed [SPEED_W-1:0] MANUAL_DRIVE = 11'sd400;
  localparam logic signed [SPEED_W-1:0] TURN_DRIVE   = 11'sd150;
  localparam logic signed [SPEED_W-1:0] CREEP_SPEED  = 11'sd75;

  // register reset values
  localparam logic [GAIN_W-1:0]         GAIN_P_RST = 16'd25600;
  localparam logic [GAIN_W-1:0]         GAIN_I_RST = 16'd0;
  localparam logic [GAIN_W-1:0]         GAIN_D_RST = 16'd25600;
  localparam logic signed [SPEED_W-1:0] BASE_RST   = 11'sd180;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P     = 3'd0,
    REG_GAIN_I     = 3'd1,
    REG_GAIN_D     = 3'd2,
    REG_CRUISE     = 3'd3,
    REG_AUTO_MODE  = 3'd4,
    REG_MANUAL_DIR = 3'd5
  } reg_idx_e;

  typedef enum logic [DIR_W-1:0] {
    DIR_STOP  = 3'd0,
    DIR_FWD   = 3'd1,
    DIR_BACK  = 3'd2,
    DIR_LEFT  = 3'd3,
    DIR_RIGHT = 3'd4
  } dir_e;

  typedef enum logic [1:0] {
    MUL_P = 2'd0,
    MUL_I = 2'd1,
    MUL_D = 2'd2
  } mul_sel_e;

  typedef enum logic [1:0] {
    RES_PID    = 2'd0,
    RES_MANUAL = 2'd1,
    RES_LOST   = 2'd2
  } res_sel_e;

  typedef struct packed {
    logic [GAIN_W-1:0]         gain_p;
    logic [GAIN_W-1:0]         gain_i;
    logic [GAIN_W-1:0]         gain_d;
    logic signed [SPEED_W-1:0] cruise_spd;
    logic                      auto_mode;
    logic [DIR_W-1:0]          manual_dir;
  } cfg_t;

  typedef struct packed {
    logic     load;
    logic     div_step;
    logic     err_en;
    logic     pid_en;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     acc_clr;
    logic     acc_add;
    logic     sum_l;
    logic     sum_r;
    logic     fin_r;
    logic     out_load;
    res_sel_e res_sel;
  } cmd_t;

  typedef struct packed {
    logic auto_mode;
    logic no_line;
  } status_t;

  // bits of the largest weight sum magnitude for n sensors
  function automatic int lfpd_mag_w(int n);
    return $clog2(128 * ((n * n) / 4) + 1);
  endfunction

endpackage

@@ sv/line_follower_pid_drive_top.sv @@
// line follower pid drive, top level joining lfpd_cfg_regs, lfpd_ctrl, lfpd_datapath (lfpd_pkg)
// auto request: the result comes from the bit-serial divider at one quotient bit a cycle,
// then the pid update, one shared multiplier over three passes, the wheel sums and the
// write; manual and line-lost requests go from dispatch straight to the write
// one request in flight, result held in an output register until taken; async active-low
// reset loads config defaults and clears the integral, last error and state machine
module line_follower_pid_drive_top import lfpd_pkg::*; #(
  parameter int NUM_SENSORS = NUM_SENSORS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [NUM_SENSORS-1:0]    sensor_bits_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [SPEED_W-1:0] left_speed_o,
  output logic signed [SPEED_W-1:0] right_speed_o,
  output logic                      line_lost_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [CFG_DATA_W-1:0]     cfg_data_i
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  lfpd_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  lfpd_ctrl #(
    .NUM_SENSORS (NUM_SENSORS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  lfpd_datapath #(
    .NUM_SENSORS (NUM_SENSORS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .sensor_bits_i (sensor_bits_i),
    .cfg_i         (cfg),
    .cmd_i         (cmd),
    .status_o      (status),
    .left_speed_o  (left_speed_o),
    .right_speed_o (right_speed_o),
    .line_lost_o   (line_lost_o)
  );

endmodule

@@ sv/lfpd_cfg_regs.sv @@
// configuration register bank of the line follower pid drive
// depends on lfpd_pkg
module lfpd_cfg_regs import lfpd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  // writes are always taken
  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // register write decode, unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_GAIN_P:     cfg_d.gain_p     = cfg_data_i;
        REG_GAIN_I:     cfg_d.gain_i     = cfg_data_i;
        REG_GAIN_D:     cfg_d.gain_d     = cfg_data_i;
        REG_CRUISE:     cfg_d.cruise_spd = signed'(cfg_data_i[SPEED_W-1:0]);
        REG_AUTO_MODE:  cfg_d.auto_mode  = cfg_data_i[0];
        REG_MANUAL_DIR: cfg_d.manual_dir = cfg_data_i[DIR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p     <= GAIN_P_RST;
      cfg_q.gain_i     <= GAIN_I_RST;
      cfg_q.gain_d     <= GAIN_D_RST;
      cfg_q.cruise_spd <= BASE_RST;
      cfg_q.auto_mode  <= 1'b1;
      cfg_q.manual_dir <= DIR_STOP;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

@@ sv/lfpd_datapath.sv @@
// datapath: centroid sum, bit-serial divider, pid state, shared multiplier,
// wheel sums and result registers; depends on lfpd_pkg
module lfpd_datapath import lfpd_pkg::*; #(
  parameter int NUM_SENSORS = NUM_SENSORS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [NUM_SENSORS-1:0]    sensor_bits_i,
  input  cfg_t                      cfg_i,
  input  cmd_t                      cmd_i,
  output status_t                   status_o,
  output logic signed [SPEED_W-1:0] left_speed_o,
  output logic signed [SPEED_W-1:0] right_speed_o,
  output logic                      line_lost_o
);

  localparam int MAG_W  = lfpd_mag_w(NUM_SENSORS);
  localparam int WSUM_W = MAG_W + 1;
  localparam int CNT_W  = $clog2(NUM_SENSORS + 1);
  localparam int REM_W  = CNT_W + 1;
  localparam int QX_W   = (MAG_W > ERR_W) ? MAG_W + 1 : ERR_W + 1;
  localparam logic [QX_W-1:0] NEG_LIM = QX_W'(1024);
  localparam logic [QX_W-1:0] POS_LIM = QX_W'(1023);

  // sensor weight in q.8, one unit apart and centred on zero
  function automatic logic signed [WSUM_W-1:0] weight(int k);
    return WSUM_W'((2 * k - (NUM_SENSORS - 1)) * 128);
  endfunction

  // wheel value: truncate toward zero, then clamp to the drive limit
  function automatic logic signed [SPEED_W-1:0] to_wheel(logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0]        sh;
    logic signed [SUM_W-FRAC_W-1:0] q;
    sh = s >>> FRAC_W;
    q  = sh[SUM_W-FRAC_W-1:0];
    if (s[SUM_W-1] && (s[FRAC_W-1:0] != '0)) begin
      q = q + {{(SUM_W-FRAC_W-1){1'b0}}, 1'b1};
    end
    if (q > DRIVE_LIMIT) begin
      return DRIVE_LIMIT;
    end else if (q < -DRIVE_LIMIT) begin
      return -DRIVE_LIMIT;
    end
    return q[SPEED_W-1:0];
  endfunction

  logic signed [WSUM_W-1:0] wsum;
  logic [CNT_W-1:0]         cnt;
  logic [MAG_W-1:0]         mag;

  logic [MAG_W-1:0]         dvd_q;
  logic [REM_W-1:0]         rem_q;
  logic [CNT_W-1:0]         dvs_q;
  logic                     neg_q;
  logic                     zero_q;
  logic [REM_W-1:0]         rem_sh;
  logic                     qbit;

  logic [QX_W-1:0]          qx;
  logic signed [ERR_W-1:0]  qs;
  logic signed [ERR_W-1:0]  err_c;
  logic signed [ERR_W-1:0]  err_q;

  logic signed [INT_W:0]    isum_w;
  logic signed [INT_W-1:0]  isum_c;
  logic signed [INT_W-1:0]  integ_q;
  logic signed [ERR_W-1:0]  last_q;
  logic signed [DIFF_W-1:0] diff_q;

  logic signed [GAIN_W:0]   mul_a;
  logic signed [INT_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [SUM_W-1:0]  base_ext;
  logic signed [SUM_W-1:0]  baseq;
  logic signed [SUM_W-1:0]  s_q;
  logic signed [SPEED_W-1:0] left_q;
  logic signed [SPEED_W-1:0] right_q;

  logic signed [SPEED_W-1:0] lspd_q, rspd_q;
  logic                      lost_q;
  logic signed [SPEED_W-1:0] lspd_d, rspd_d;
  logic                      lost_d;

  // weighted sum and active count of the sensors
  always_comb begin
    wsum = '0;
    cnt  = '0;
    for (int k = 0; k < NUM_SENSORS; k++) begin
      if (sensor_bits_i[k]) begin
        wsum = wsum + weight(k);
        cnt  = cnt + CNT_W'(1);
      end
    end
  end

  assign mag = wsum[WSUM_W-1] ? MAG_W'(-wsum) : MAG_W'(wsum);

  // one restoring division step on the magnitude
  assign rem_sh = {rem_q[CNT_W-1:0], dvd_q[MAG_W-1]};
  assign qbit   = (rem_sh >= {1'b0, dvs_q});

  // signed quotient saturated to the error range
  always_comb begin
    qx = QX_W'(dvd_q);
    qs = signed'(qx[ERR_W-1:0]);
    if (neg_q) begin
      err_c = (qx > NEG_LIM) ? ERR_MIN : -qs;
    end else begin
      err_c = (qx > POS_LIM) ? ERR_MAX : qs;
    end
  end

  // saturating integral update
  always_comb begin
    isum_w = (INT_W+1)'(integ_q) + (INT_W+1)'(err_q);
    if (isum_w > (INT_W+1)'(INT_MAX)) begin
      isum_c = INT_MAX;
    end else if (isum_w < (INT_W+1)'(INT_MIN)) begin
      isum_c = INT_MIN;
    end else begin
      isum_c = isum_w[INT_W-1:0];
    end
  end

  // shared multiplier operand select
  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_P: begin
        mul_a = signed'({1'b0, cfg_i.gain_p});
        mul_b = INT_W'(err_q);
      end
      MUL_I: begin
        mul_a = signed'({1'b0, cfg_i.gain_i});
        mul_b = integ_q;
      end
      MUL_D: begin
        mul_a = signed'({1'b0, cfg_i.gain_d});
        mul_b = INT_W'(diff_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign base_ext = SUM_W'(cfg_i.cruise_spd);
  assign baseq    = base_ext <<< FRAC_W;

  // result select for the output register
  always_comb begin
    lspd_d = left_q;
    rspd_d = right_q;
    lost_d = 1'b0;
    unique case (cmd_i.res_sel)
      RES_PID: ;
      RES_LOST: begin
        lost_d = 1'b1;
        priority if (last_q < -HALF_UNIT) begin
          lspd_d = -TURN_DRIVE;
          rspd_d = TURN_DRIVE;
        end else if (last_q > HALF_UNIT) begin
          lspd_d = TURN_DRIVE;
          rspd_d = -TURN_DRIVE;
        end else begin
          lspd_d = CREEP_SPEED;
          rspd_d = CREEP_SPEED;
        end
      end
      RES_MANUAL: begin
        unique case (cfg_i.manual_dir)
          DIR_FWD: begin
            lspd_d = MANUAL_DRIVE;
            rspd_d = MANUAL_DRIVE;
          end
          DIR_BACK: begin
            lspd_d = -MANUAL_DRIVE;
            rspd_d = -MANUAL_DRIVE;
          end
          DIR_LEFT: begin
            lspd_d = -MANUAL_DRIVE;
            rspd_d = MANUAL_DRIVE;
          end
          DIR_RIGHT: begin
            lspd_d = MANUAL_DRIVE;
            rspd_d = -MANUAL_DRIVE;
          end
          default: begin
            lspd_d = '0;
            rspd_d = '0;
          end
        endcase
      end
      default: ;
    endcase
  end

  // pid state, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      last_q  <= '0;
    end else if (cmd_i.pid_en) begin
      integ_q <= isum_c;
      last_q  <= err_q;
    end
  end

  // working registers of one request
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dvd_q  <= mag;
      rem_q  <= '0;
      dvs_q  <= cnt;
      neg_q  <= wsum[WSUM_W-1];
      zero_q <= (cnt == '0);
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[MAG_W-2:0], qbit};
      rem_q <= qbit ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
    end
    if (cmd_i.err_en) begin
      err_q <= err_c;
    end
    if (cmd_i.pid_en) begin
      diff_q <= DIFF_W'(err_q) - DIFF_W'(last_q);
    end
    if (cmd_i.mul_en) begin
      prod_q <= mul_a * mul_b;
    end
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
    if (cmd_i.sum_l) begin
      s_q <= baseq - SUM_W'(acc_q);
    end else if (cmd_i.sum_r) begin
      s_q <= baseq + SUM_W'(acc_q);
    end
    if (cmd_i.sum_r) begin
      left_q <= to_wheel(s_q);
    end
    if (cmd_i.fin_r) begin
      right_q <= to_wheel(s_q);
    end
    if (cmd_i.out_load) begin
      lspd_q <= lspd_d;
      rspd_q <= rspd_d;
      lost_q <= lost_d;
    end
  end

  assign status_o.auto_mode = cfg_i.auto_mode;
  assign status_o.no_line   = zero_q;

  assign left_speed_o  = lspd_q;
  assign right_speed_o = rspd_q;
  assign line_lost_o   = lost_q;

endmodule

@@ sv/lfpd_ctrl.sv @@
// controller state machine: sequences divider, pid update, multiplier passes
// and the output handshake; depends on lfpd_pkg
module lfpd_ctrl import lfpd_pkg::*; #(
  parameter int NUM_SENSORS = NUM_SENSORS_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  localparam int MAG_W  = lfpd_mag_w(NUM_SENSORS);
  localparam int STEP_W = $clog2(MAG_W);

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_DIV, S_ERR, S_PID, S_MUL_P, S_MUL_I, S_MUL_D,
    S_ACC, S_SUM_L, S_SUM_R, S_FIN_R, S_WRITE
  } state_e;

  state_e           state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  res_sel_e         res_q, res_d;
  logic             out_valid_q, out_valid_d;
  logic             take;
  logic             load_out;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign take        = in_valid_i && in_ready_o;
  assign load_out    = (state_q == S_WRITE) && (!out_valid_q || out_ready_i);

  // datapath commands per state
  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = take;
    cmd_o.div_step = (state_q == S_DIV);
    cmd_o.err_en   = (state_q == S_ERR);
    cmd_o.pid_en   = (state_q == S_PID);
    cmd_o.mul_en   = (state_q == S_MUL_P) || (state_q == S_MUL_I) ||
                     (state_q == S_MUL_D);
    cmd_o.acc_clr  = (state_q == S_MUL_P);
    cmd_o.acc_add  = (state_q == S_MUL_I) || (state_q == S_MUL_D) ||
                     (state_q == S_ACC);
    cmd_o.sum_l    = (state_q == S_SUM_L);
    cmd_o.sum_r    = (state_q == S_SUM_R);
    cmd_o.fin_r    = (state_q == S_FIN_R);
    cmd_o.out_load = load_out;
    cmd_o.res_sel  = res_q;
    unique case (state_q)
      S_MUL_I: cmd_o.mul_sel = MUL_I;
      S_MUL_D: cmd_o.mul_sel = MUL_D;
      default: cmd_o.mul_sel = MUL_P;
    endcase
  end

  // next state
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    res_d       = res_q;
    out_valid_d = load_out ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
    unique case (state_q)
      S_IDLE: begin
        if (take) begin
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        priority if (!status_i.auto_mode) begin
          res_d   = RES_MANUAL;
          state_d = S_WRITE;
        end else if (status_i.no_line) begin
          res_d   = RES_LOST;
          state_d = S_WRITE;
        end else begin
          res_d   = RES_PID;
          step_d  = STEP_W'(MAG_W - 1);
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (step_q == '0) begin
          state_d = S_ERR;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      S_ERR:   state_d = S_PID;
      S_PID:   state_d = S_MUL_P;
      S_MUL_P: state_d = S_MUL_I;
      S_MUL_I: state_d = S_MUL_D;
      S_MUL_D: state_d = S_ACC;
      S_ACC:   state_d = S_SUM_L;
      S_SUM_L: state_d = S_SUM_R;
      S_SUM_R: state_d = S_FIN_R;
      S_FIN_R: state_d = S_WRITE;
      S_WRITE: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      res_q       <= RES_PID;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ sv/lfpd_checker.sv @@
// port-level checks of the line follower pid drive, bound to the top level
// depends on lfpd_pkg and line_follower_pid_drive_top
module lfpd_checker import lfpd_pkg::*; (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic signed [SPEED_W-1:0] left_speed_o,
  input logic signed [SPEED_W-1:0] right_speed_o,
  input logic                      line_lost_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(left_speed_o) &&
      $stable(right_speed_o) && $stable(line_lost_o))
    else $error("stalled result changed");

  // wheel drives stay within the clamp
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> left_speed_o <= DRIVE_LIMIT && left_speed_o >= -DRIVE_LIMIT &&
      right_speed_o <= DRIVE_LIMIT && right_speed_o >= -DRIVE_LIMIT)
    else $error("wheel drive beyond limit");

  // line lost gives only the pivot or creep patterns
  a_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && line_lost_o |->
      (left_speed_o == -TURN_DRIVE && right_speed_o == TURN_DRIVE) ||
      (left_speed_o == TURN_DRIVE && right_speed_o == -TURN_DRIVE) ||
      (left_speed_o == CREEP_SPEED && right_speed_o == CREEP_SPEED))
    else $error("bad line lost pattern");

  // one request in flight at a time
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while busy");

endmodule

bind line_follower_pid_drive_top lfpd_checker u_checker (.*);
